// ----- hdl/irpdt_pkg.sv -----
// types, codes and reset constants for the ir pulse-distance transmitter
// no dependencies
`default_nettype none

package irpdt_pkg;

    localparam int FRAME_BITS_DEF  = 32;
    localparam int COUNT_WIDTH_DEF = 12;
    localparam int WORD_W          = 32;
    localparam int CFG_W           = 12;
    localparam int CFG_IDX_W       = 3;

    localparam logic [CFG_W-1:0] HEADER_MARK_RST  = 12'd692;
    localparam logic [CFG_W-1:0] HEADER_SPACE_RST = 12'd346;
    localparam logic [CFG_W-1:0] BIT_MARK_RST     = 12'd43;
    localparam logic [CFG_W-1:0] ZERO_SPACE_RST   = 12'd43;
    localparam logic [CFG_W-1:0] ONE_SPACE_RST    = 12'd129;
    localparam logic [CFG_W-1:0] STOP_MARK_RST    = 12'd43;

    typedef enum logic [0:0] {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER_MARK  = 3'd0,
        REG_HEADER_SPACE = 3'd1,
        REG_BIT_MARK     = 3'd2,
        REG_ZERO_SPACE   = 3'd3,
        REG_ONE_SPACE    = 3'd4,
        REG_STOP_MARK    = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2,
        PH_STOP   = 2'd3
    } phase_t;

    typedef struct packed {
        op_t               op;
        logic [WORD_W-1:0] frame_word;
    } cmd_t;

    typedef struct packed {
        logic ir_level;
        logic busy_res;
        logic frame_done;
    } res_t;

endpackage

`default_nettype wire

// ----- hdl/ir_pulse_distance_transmitter.sv -----
// ir pulse-distance transmitter top level: frame sequencer and result register
// depends on irpdt_pkg
`default_nettype none

// usage
//   cmd channel: one beat is either a tick (one carrier half-period) or a
//   start that loads frame_word; a start during a frame is dropped
//   res channel: exactly one beat per cmd beat with the emitter level,
//   busy flag and frame_done (set on the tick that ends the stop mark)
//   cfg channel: six 12-bit timing registers, always ready, write only
//   while the transmitter is idle
// timing
//   a result is registered and appears in the cycle after its cmd beat is taken;
//   one cmd beat is taken every cycle unless a held result stalls it, as the
//   sequencer update goes straight into the result register
//   when res_ready is low with a result held, cmd_ready drops until the
//   held beat is taken
// reset
//   timing registers return to their defaults, sequencer goes idle with the
//   emitter low, no result pending

module ir_pulse_distance_transmitter
    import irpdt_pkg::*;
#(
    parameter int FRAME_BITS  = FRAME_BITS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output      logic                 cmd_ready,
    input  wire cmd_t                 cmd_data,
    output      logic                 res_valid,
    input  wire logic                 res_ready,
    output      res_t                 res_data,
    input  wire logic                 cfg_valid,
    output      logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int BL_W = $clog2(FRAME_BITS + 1);

    logic [CFG_W-1:0] header_mark_reg;
    logic [CFG_W-1:0] header_space_reg;
    logic [CFG_W-1:0] bit_mark_reg;
    logic [CFG_W-1:0] zero_space_reg;
    logic [CFG_W-1:0] one_space_reg;
    logic [CFG_W-1:0] stop_mark_reg;

    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] mark_reg, mark_next;
    logic [COUNT_WIDTH-1:0] space_reg, space_next;
    logic [FRAME_BITS-1:0]  shift_reg, shift_next;
    logic [BL_W-1:0]        bits_left_reg, bits_left_next;
    logic                   pin_reg, pin_next;
    logic                   done_next;

    logic res_valid_reg;
    res_t res_data_reg;
    logic cmd_fire;

    assign cfg_ready = 1'b1;
    assign cmd_ready = !res_valid_reg || res_ready;
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_mark_reg  <= HEADER_MARK_RST;
            header_space_reg <= HEADER_SPACE_RST;
            bit_mark_reg     <= BIT_MARK_RST;
            zero_space_reg   <= ZERO_SPACE_RST;
            one_space_reg    <= ONE_SPACE_RST;
            stop_mark_reg    <= STOP_MARK_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HEADER_MARK:  header_mark_reg  <= cfg_data;
                REG_HEADER_SPACE: header_space_reg <= cfg_data;
                REG_BIT_MARK:     bit_mark_reg     <= cfg_data;
                REG_ZERO_SPACE:   zero_space_reg   <= cfg_data;
                REG_ONE_SPACE:    one_space_reg    <= cfg_data;
                REG_STOP_MARK:    stop_mark_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            mark_reg      <= '0;
            space_reg     <= '0;
            shift_reg     <= '0;
            bits_left_reg <= '0;
            pin_reg       <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            mark_reg      <= mark_next;
            space_reg     <= space_next;
            shift_reg     <= shift_next;
            bits_left_reg <= bits_left_next;
            pin_reg       <= pin_next;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        mark_next      = mark_reg;
        space_next     = space_reg;
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        pin_next       = pin_reg;
        done_next      = 1'b0;
        if (cmd_fire)
        begin
            if (cmd_data.op == OP_START)
            begin
                if (phase_reg == PH_IDLE)
                begin
                    shift_next     = FRAME_BITS'(cmd_data.frame_word);
                    bits_left_next = BL_W'(FRAME_BITS);
                    mark_next      = COUNT_WIDTH'(header_mark_reg);
                    space_next     = COUNT_WIDTH'(header_space_reg);
                    phase_next     = PH_HEADER;
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                if (mark_next != '0)
                begin
                    mark_next = mark_next - COUNT_WIDTH'(1);
                    pin_next  = !pin_next;
                end
                else if (space_next != '0)
                begin
                    space_next = space_next - COUNT_WIDTH'(1);
                    pin_next   = 1'b0;
                end
                if ((phase_next == PH_HEADER || phase_next == PH_DATA)
                    && mark_next == '0 && space_next == '0)
                begin
                    if (bits_left_next != '0)
                    begin
                        mark_next      = COUNT_WIDTH'(bit_mark_reg);
                        space_next     = shift_next[FRAME_BITS-1]
                                       ? COUNT_WIDTH'(one_space_reg)
                                       : COUNT_WIDTH'(zero_space_reg);
                        shift_next     = shift_next << 1;
                        bits_left_next = bits_left_next - BL_W'(1);
                        phase_next     = PH_DATA;
                    end
                    else
                    begin
                        mark_next  = COUNT_WIDTH'(stop_mark_reg);
                        phase_next = PH_STOP;
                    end
                end
                if (phase_next == PH_STOP && mark_next == '0)
                begin
                    pin_next   = 1'b0;
                    space_next = '0;
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            res_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            res_data_reg.ir_level   <= pin_next;
            res_data_reg.busy_res   <= (phase_next != PH_IDLE);
            res_data_reg.frame_done <= done_next;
        end
    end

`ifndef ASSERT_OFF
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_data.frame_done && res_data.busy_res))
        else $error("frame_done reported with busy set");

    a_idle_pin_low: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> !pin_reg)
        else $error("emitter high while idle");

    a_idle_no_bits: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> bits_left_reg == '0)
        else $error("bits pending while idle");

    a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && cmd_data.op == OP_START && phase_reg == PH_IDLE
        |=> phase_reg == PH_HEADER && res_valid)
        else $error("start beat did not open a frame");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid_reg |-> cmd_ready)
        else $error("cmd stalled with empty result register");
`endif

endmodule

`default_nettype wire

// ----- bench/ir_pulse_distance_transmitter_tb.sv -----
// testbench for the ir pulse-distance transmitter: directed rows, timing sweeps, random frames
// results are checked beat by beat against an in-bench model of the frame sequencer
// depends on irpdt_pkg and ir_pulse_distance_transmitter
`timescale 1ns / 1ps

module ir_pulse_distance_transmitter_tb;
    import irpdt_pkg::*;

    localparam int NUM_REGS = int'(REG_STOP_MARK) + 1;
    localparam logic [CFG_IDX_W-1:0] UNUSED_REG = 3'd6;
    localparam int DIR_ROWS = 8;

    typedef struct packed {
        op_t               op;
        logic [WORD_W-1:0] word;
        logic              typed;
        res_t              want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    cmd_t cmd_data = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    res_t res_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    // sequencer model state
    phase_t tx_phase = PH_IDLE;
    logic [CFG_W-1:0] mark_left = '0;
    logic [CFG_W-1:0] space_left = '0;
    logic [WORD_W-1:0] code_sr = '0;
    logic [5:0] bits_rem = '0;
    logic pin_q = 1'b0;
    logic [CFG_W-1:0] timing [NUM_REGS] = '{HEADER_MARK_RST, HEADER_SPACE_RST, BIT_MARK_RST,
                                           ZERO_SPACE_RST, ONE_SPACE_RST, STOP_MARK_RST};
    logic [CFG_W-1:0] next_tim [NUM_REGS];

    res_t tx_want_q [$];
    int errs = 0;
    int res_beats = 0;
    bit send_idle_on = 1'b0;
    bit recv_idle_on = 1'b0;
    bit unused_hit = 1'b0;
    int stall_left = 0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{OP_TICK,  32'h0000_0000, 1'b1, '{1'b0, 1'b0, 1'b0}},
        '{OP_TICK,  32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 1'b0}},
        '{OP_START, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b1, 1'b0}},
        '{OP_START, 32'h0000_0000, 1'b1, '{1'b0, 1'b1, 1'b0}},
        '{OP_TICK,  32'h1234_5678, 1'b1, '{1'b1, 1'b1, 1'b0}},
        '{OP_TICK,  32'h0000_0000, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{OP_START, 32'hA5A5_A5A5, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{OP_TICK,  32'hFFFF_FFFF, 1'b0, '{1'b0, 1'b0, 1'b0}}
    };

    ir_pulse_distance_transmitter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #40000000;
        $display("simulation failed");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        if (errs < 30)
        begin
            $display("mismatch at result beat %0d: %s", res_beats, what);
        end
        errs++;
    endtask

    function automatic res_t tx_step(input cmd_t c);
        res_t r;
        logic done;
        done = 1'b0;
        if (c.op == OP_START)
        begin
            if (tx_phase == PH_IDLE)
            begin
                code_sr = c.frame_word;
                bits_rem = 6'd32;
                mark_left = timing[REG_HEADER_MARK];
                space_left = timing[REG_HEADER_SPACE];
                tx_phase = PH_HEADER;
            end
        end
        else if (tx_phase != PH_IDLE)
        begin
            if (mark_left != '0)
            begin
                mark_left = mark_left - CFG_W'(1);
                pin_q = ~pin_q;
            end
            else if (space_left != '0)
            begin
                space_left = space_left - CFG_W'(1);
                pin_q = 1'b0;
            end
            if ((tx_phase == PH_HEADER || tx_phase == PH_DATA) &&
                mark_left == '0 && space_left == '0)
            begin
                if (bits_rem != '0)
                begin
                    mark_left = timing[REG_BIT_MARK];
                    space_left = code_sr[WORD_W-1] ? timing[REG_ONE_SPACE]
                                                   : timing[REG_ZERO_SPACE];
                    code_sr = code_sr << 1;
                    bits_rem = bits_rem - 6'd1;
                    tx_phase = PH_DATA;
                end
                else
                begin
                    tx_phase = PH_STOP;
                    mark_left = timing[REG_STOP_MARK];
                end
            end
            if (tx_phase == PH_STOP && mark_left == '0)
            begin
                pin_q = 1'b0;
                space_left = '0;
                tx_phase = PH_IDLE;
                done = 1'b1;
            end
        end
        r.ir_level = pin_q;
        r.busy_res = (tx_phase != PH_IDLE);
        r.frame_done = done;
        return r;
    endfunction

    // returns at the edge where the beat is taken; valid stays high for a following beat
    task automatic push_cmd(input op_t op, input logic [WORD_W-1:0] word, input logic typed,
                            input res_t want);
        cmd_t c;
        res_t pred;
        c.op = op;
        c.frame_word = word;
        if (send_idle_on && $urandom_range(0, 13) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data <= c;
        @(posedge clk);
        while (!cmd_ready)
        begin
            @(posedge clk);
        end
        pred = tx_step(c);
        tx_want_q.push_back(typed ? want : pred);
    endtask

    task automatic hold_until_drained();
        cmd_valid <= 1'b0;
        while (tx_want_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic drain_frame();
        while (tx_phase != PH_IDLE)
        begin
            push_cmd(OP_TICK, $urandom, 1'b0, '0);
        end
    endtask

    task automatic set_timings(input logic [CFG_W-1:0] hm, input logic [CFG_W-1:0] hs,
                               input logic [CFG_W-1:0] bm, input logic [CFG_W-1:0] zs,
                               input logic [CFG_W-1:0] os, input logic [CFG_W-1:0] sm);
        next_tim[REG_HEADER_MARK] = hm;
        next_tim[REG_HEADER_SPACE] = hs;
        next_tim[REG_BIT_MARK] = bm;
        next_tim[REG_ZERO_SPACE] = zs;
        next_tim[REG_ONE_SPACE] = os;
        next_tim[REG_STOP_MARK] = sm;
    endtask

    task automatic pick_timings(input int top);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            next_tim[i] = ($urandom_range(0, 5) == 0) ? '0 : CFG_W'($urandom_range(1, top));
        end
    endtask

    task automatic apply_timings();
        drain_frame();
        hold_until_drained();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= next_tim[i];
            @(posedge clk);
            while (!cfg_ready)
            begin
                @(posedge clk);
            end
            timing[i] = next_tim[i];
        end
        if (!unused_hit)
        begin
            cfg_index <= UNUSED_REG;
            cfg_data <= '1;
            @(posedge clk);
            while (!cfg_ready)
            begin
                @(posedge clk);
            end
            unused_hit = 1'b1;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int n, input bit pause_mid);
        op_t op;
        logic [WORD_W-1:0] word;
        for (int i = 0; i < n; i++)
        begin
            if (tx_phase == PH_IDLE)
            begin
                op = ($urandom_range(0, 3) != 0) ? OP_START : OP_TICK;
            end
            else
            begin
                op = ($urandom_range(0, 24) == 0) ? OP_START : OP_TICK;
            end
            case ($urandom_range(0, 7))
                0: word = '0;
                1: word = '1;
                default: word = $urandom;
            endcase
            push_cmd(op, word, 1'b0, '0);
            if (pause_mid && i == n / 2)
            begin
                hold_until_drained();
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            res_ready <= (stall_left == 1);
        end
        else if (recv_idle_on && $urandom_range(0, 11) == 0)
        begin
            stall_left <= $urandom_range(1, 17);
            res_ready <= 1'b0;
        end
        else
        begin
            res_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : res_check
        res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (tx_want_q.size() == 0)
            begin
                flag_mismatch("result beat with nothing pending");
            end
            else
            begin
                want = tx_want_q.pop_front();
                if (res_data.ir_level !== want.ir_level)
                begin
                    flag_mismatch($sformatf("ir_level %b, want %b",
                                            res_data.ir_level, want.ir_level));
                end
                if (res_data.busy_res !== want.busy_res)
                begin
                    flag_mismatch($sformatf("busy_res %b, want %b",
                                            res_data.busy_res, want.busy_res));
                end
                if (res_data.frame_done !== want.frame_done)
                begin
                    flag_mismatch($sformatf("frame_done %b, want %b",
                                            res_data.frame_done, want.frame_done));
                end
            end
            res_beats++;
        end
    end

    initial
    begin : stim
        int waited;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;

        // reset timing, one full frame
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            push_cmd(dir_rows[i].op, dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
        end
        drain_frame();

        set_timings('0, '0, '0, '0, '0, '0);
        apply_timings();
        run_random(100, 1'b0);

        set_timings(12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1);
        apply_timings();
        run_random(150, 1'b0);

        // long counts, no idling
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        set_timings('1, '1, 12'd1, '0, '1, '1);
        apply_timings();
        push_cmd(OP_START, 32'h0000_0001, 1'b0, '0);
        set_timings('0, '0, 12'd1, '1, '0, '0);
        apply_timings();
        push_cmd(OP_START, 32'hFFFF_FFFE, 1'b0, '0);
        drain_frame();
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;

        for (int k = 0; k < 5; k++)
        begin
            pick_timings((k == 2) ? 12 : 3);
            apply_timings();
            run_random(220, k == 1);
        end

        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        pick_timings(3);
        apply_timings();
        run_random(200, 1'b0);

        cmd_valid <= 1'b0;
        waited = 0;
        while (tx_want_q.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        if (tx_want_q.size() != 0)
        begin
            flag_mismatch($sformatf("%0d results never arrived", tx_want_q.size()));
        end
        repeat (8) @(posedge clk);
        if (errs == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
